FILE: src/tds_pkg.sv
// shared constants and types for the 2x2 tile downscaler
package tds_pkg;

  // sizing
  localparam int MAX_TILE    = 1024;
  localparam int MAX_SAMPLES = 4;
  localparam int SAMPLE_BITS = 32;
  localparam int LINE_DEPTH  = (MAX_TILE / 2) * MAX_SAMPLES;

  // derived widths
  localparam int SIZE_W  = $clog2(MAX_TILE) + 1;     // holds MAX_TILE itself
  localparam int POS_W   = $clog2(MAX_TILE);         // row and column position
  localparam int SPP_W   = $clog2(MAX_SAMPLES) + 1;  // holds MAX_SAMPLES itself
  localparam int SMP_W   = $clog2(MAX_SAMPLES);      // sample slot
  localparam int LINE_AW = $clog2(LINE_DEPTH);
  localparam int PAIR_W  = SAMPLE_BITS + 1;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = SIZE_W;

  // register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_TILE_SIZE   = 2'd0,
    REG_SAMPLES     = 2'd1,
    REG_INTERP_MODE = 2'd2
  } tds_reg_t;

  // reset values
  localparam logic [SIZE_W-1:0] TILE_SIZE_RST = SIZE_W'(512);
  localparam logic [SPP_W-1:0]  SPP_RST       = SPP_W'(3);
  localparam logic              MODE_RST      = 1'b1;

  // result waiting on the line store read
  typedef struct packed {
    logic              last;
    logic              mode;
    logic [PAIR_W-1:0] pair;
  } tds_stage_t;

endpackage

FILE: src/tile_downscale_2x2.sv
// 2x2 box filter / nearest downsampler for one square tile, built around a line store
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_write            cfg_index, cfg_data
//   in       in         in_valid / in_stall  sample_value
//   out      out        out_valid / out_stall scaled_value, tile_last
//
// one input beat per cycle while in_stall is low; after the beat that completes its 2x2 block,
// a result passes the line store read (read stage) and then the output register
// the line store has one write or one read per cycle, which sets the one-beat-per-cycle rate
// rst clears counters, config and valids; the line store is not cleared (each entry is
// written in an even row before the odd row reads it)
// in_stall rises only while a finished result waits behind a stalled output register
module tile_downscale_2x2 (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tds_pkg::CFG_AW-1:0]      cfg_index,
  input  logic [tds_pkg::CFG_DW-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tds_pkg::SAMPLE_BITS-1:0] sample_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tds_pkg::SAMPLE_BITS-1:0] scaled_value,
  output logic                            tile_last
);
  import tds_pkg::*;

  // configuration, stored already clamped
  logic [SIZE_W-1:0] size_eff;
  logic [SPP_W-1:0]  spp_eff;
  logic              mode;

  // position of the next beat
  logic [POS_W-1:0] row_count;
  logic [POS_W-1:0] column_count;
  logic [SMP_W-1:0] sample_count;

  logic [SAMPLE_BITS-1:0] left_sample_hold [MAX_SAMPLES];

  // line store
  logic [PAIR_W-1:0] line_mem [LINE_DEPTH];
  logic [PAIR_W-1:0] line_q;

  // read stage and output register
  logic       s1_valid;
  tds_stage_t s1;

  logic              in_acc;
  logic              s1_move;
  logic [SIZE_W-1:0] used;
  logic              in_area;
  logic              odd_row;
  logic              odd_col;
  logic [LINE_AW-1:0] line_idx;
  logic [SIZE_W+SPP_W-1:0] line_prod;
  logic [PAIR_W-1:0] pair_new;
  logic              last_beat;
  logic              smp_wrap;
  logic              col_wrap;
  logic              row_wrap;
  logic [PAIR_W:0]   sum_full;
  logic [SAMPLE_BITS-1:0] result;
  logic [SIZE_W-1:0] cfg_size;
  logic [SPP_W-1:0]  cfg_spp;
  logic              cfg_hit;

  // handshake
  assign s1_move  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // position decode
  assign used      = {size_eff[SIZE_W-1:1], 1'b0};
  assign in_area   = ({1'b0, row_count} < used) && ({1'b0, column_count} < used);
  assign odd_row   = row_count[0];
  assign odd_col   = column_count[0];
  assign line_prod = {{(SPP_W+2){1'b0}}, column_count[POS_W-1:1]} * {{SIZE_W{1'b0}}, spp_eff};
  assign line_idx  = LINE_AW'(line_prod + (SIZE_W+SPP_W)'(sample_count));
  assign pair_new  = mode ? ({1'b0, left_sample_hold[sample_count]} + {1'b0, sample_value})
                          : {1'b0, left_sample_hold[sample_count]};
  assign last_beat = ({1'b0, row_count} == used - SIZE_W'(1))
                  && ({1'b0, column_count} == used - SIZE_W'(1))
                  && ({1'b0, sample_count} == spp_eff - SPP_W'(1));

  // counter wrap points
  assign smp_wrap = (SPP_W'(sample_count) + SPP_W'(1)) >= spp_eff;
  assign col_wrap = (SIZE_W'(column_count) + SIZE_W'(1)) >= size_eff;
  assign row_wrap = (SIZE_W'(row_count) + SIZE_W'(1)) >= size_eff;

  // config clamping
  assign cfg_hit  = cfg_write && (cfg_index == REG_TILE_SIZE || cfg_index == REG_SAMPLES
                                  || cfg_index == REG_INTERP_MODE);
  assign cfg_size = (cfg_data < SIZE_W'(2)) ? SIZE_W'(2)
                  : (cfg_data > SIZE_W'(MAX_TILE)) ? SIZE_W'(MAX_TILE) : cfg_data;
  assign cfg_spp  = (cfg_data[SPP_W-1:0] == '0) ? SPP_W'(1)
                  : (cfg_data[SPP_W-1:0] > SPP_W'(MAX_SAMPLES)) ? SPP_W'(MAX_SAMPLES)
                  : cfg_data[SPP_W-1:0];

  // final arithmetic on the read data
  assign sum_full = {1'b0, line_q} + {1'b0, s1.pair};
  assign result   = s1.mode ? sum_full[SAMPLE_BITS+1:2] : line_q[SAMPLE_BITS-1:0];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_eff <= TILE_SIZE_RST;
      spp_eff  <= SPP_RST;
      mode     <= MODE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TILE_SIZE:   size_eff <= cfg_size;
        REG_SAMPLES:     spp_eff  <= cfg_spp;
        REG_INTERP_MODE: mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_count    <= '0;
      column_count <= '0;
      sample_count <= '0;
    end else if (in_acc) begin
      if (smp_wrap) begin
        sample_count <= '0;
        if (col_wrap) begin
          column_count <= '0;
          row_count    <= row_wrap ? '0 : row_count + POS_W'(1);
        end else begin
          column_count <= column_count + POS_W'(1);
        end
      end else begin
        sample_count <= sample_count + SMP_W'(1);
      end
    end
  end

  // even-column sample hold
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SAMPLES; i++) left_sample_hold[i] <= '0;
    end else if (in_acc && in_area && !odd_col) begin
      left_sample_hold[sample_count] <= sample_value;
    end
  end

  // line store: write in even rows, read in odd rows
  always_ff @(posedge clk) begin
    if (in_acc && in_area && odd_col) begin
      if (!odd_row) begin
        line_mem[line_idx] <= pair_new;
      end else begin
        line_q <= line_mem[line_idx];
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      s1_valid <= 1'b0;
    end else if (in_acc && in_area && odd_col && odd_row) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (in_acc && in_area && odd_col && odd_row) begin
      s1.last <= last_beat;
      s1.mode <= mode;
      s1.pair <= {1'b0, left_sample_hold[sample_count]} + {1'b0, sample_value};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_move) begin
      scaled_value <= result;
      tile_last    <= s1.last;
    end
  end

  // counters stay inside the tile
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, sample_count} < spp_eff) && ({1'b0, column_count} < size_eff)
    && ({1'b0, row_count} < size_eff))
    else $error("position counter outside tile");

  // a read result not blocked reaches the output register next cycle
  a_s1_advance: assert property (@(posedge clk) disable iff (rst || cfg_hit)
    (s1_valid && !(out_valid && out_stall)) |=> out_valid)
    else $error("read stage result lost");

  // a line store read on an odd row of an odd column always enters the read stage
  a_read_pos: assert property (@(posedge clk) disable iff (rst || cfg_hit)
    (in_acc && in_area && odd_col && odd_row) |=> s1_valid)
    else $error("odd row block did not enter read stage");

endmodule
